/* design/cdvh_pkg.sv */
`default_nettype none

package cdvh_pkg;

    localparam int MAX_LEVEL   = 300;
    localparam int MAX_VOXELS  = 1048576;
    localparam int NUM_CELLS   = MAX_LEVEL + 1;

    localparam int DOSE_W      = 32;
    localparam int FRAC_W      = 8;
    localparam int STEP_W      = 16;
    localparam int UNIT_W      = STEP_W + FRAC_W;
    localparam int LEVEL_W     = 9;
    localparam int OUT_CNT_W   = 21;
    localparam int CNT_W       = $clog2(MAX_VOXELS + 1);
    localparam int LVL_W       = $clog2(MAX_LEVEL + 1);
    localparam int IDX_W       = (LVL_W > LEVEL_W) ? LVL_W : LEVEL_W;
    localparam int INFL_W      = $clog2(NUM_CELLS + 1);

    localparam logic [STEP_W-1:0] DOSE_STEP_RST = STEP_W'(100);
    localparam logic [CNT_W-1:0]  CNT_MAX       = CNT_W'(MAX_VOXELS);

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        CLS_PROSTATE = 2'd0,
        CLS_URETHRA  = 2'd1,
        CLS_RECTUM   = 2'd2,
        CLS_NORMAL   = 2'd3
    } t_cls;

    localparam int NUM_CLS = 4;

    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        logic                valid;
        t_cmd                cmd;
        t_cls                cls;
        logic                below;
        logic [DOSE_W-1:0]   rem;
        logic [UNIT_W-1:0]   unit;
        logic [LEVEL_W-1:0]  level;
        t_cnt                cnt_prostate;
        t_cnt                cnt_urethra;
        t_cnt                cnt_rectum;
        t_cnt                cnt_normal;
    } t_beat;

endpackage

`default_nettype wire

/* design/cdvh_cell.sv */
`default_nettype none

module cdvh_cell (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [cdvh_pkg::IDX_W-1:0]  i_index,
    input  wire cdvh_pkg::t_beat             i_beat,
    output cdvh_pkg::t_beat                  o_beat
);

    logic                              r_vld;
    cdvh_pkg::t_beat                   r_pay;
    cdvh_pkg::t_beat                   n_pay;
    cdvh_pkg::t_cnt                    r_cnt [cdvh_pkg::NUM_CLS];
    cdvh_pkg::t_cnt                    n_cnt [cdvh_pkg::NUM_CLS];
    logic [cdvh_pkg::DOSE_W:0]         w_diff;
    logic                              w_hit;
    logic                              w_clr;
    logic                              w_match;

    assign w_hit   = i_beat.valid && (i_beat.cmd == cdvh_pkg::CMD_ADD) && !i_beat.below;
    assign w_clr   = i_beat.valid && (i_beat.cmd == cdvh_pkg::CMD_CLEAR);
    assign w_match = i_beat.valid && (i_beat.cmd == cdvh_pkg::CMD_QUERY)
                     && (cdvh_pkg::IDX_W'(i_beat.level) == i_index);
    assign w_diff  = {1'b0, i_beat.rem}
                     - {{(cdvh_pkg::DOSE_W + 1 - cdvh_pkg::UNIT_W){1'b0}}, i_beat.unit};

    always_comb begin
        for (int c = 0; c < cdvh_pkg::NUM_CLS; c++) begin
            n_cnt[c] = r_cnt[c];
            if (w_clr) begin
                n_cnt[c] = '0;
            end else if (w_hit && (i_beat.cls == cdvh_pkg::t_cls'(c))
                         && (r_cnt[c] < cdvh_pkg::CNT_MAX)) begin
                n_cnt[c] = r_cnt[c] + cdvh_pkg::CNT_W'(1);
            end
        end
    end

    // threshold of the next level: remainder minus one step, sticky once below
    always_comb begin
        n_pay = i_beat;
        if (!i_beat.below) begin
            if (w_diff[cdvh_pkg::DOSE_W]) begin
                n_pay.below = 1'b1;
            end else begin
                n_pay.rem = w_diff[cdvh_pkg::DOSE_W-1:0];
            end
        end
        if (w_match) begin
            n_pay.cnt_prostate = r_cnt[cdvh_pkg::CLS_PROSTATE];
            n_pay.cnt_urethra  = r_cnt[cdvh_pkg::CLS_URETHRA];
            n_pay.cnt_rectum   = r_cnt[cdvh_pkg::CLS_RECTUM];
            n_pay.cnt_normal   = r_cnt[cdvh_pkg::CLS_NORMAL];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            for (int c = 0; c < cdvh_pkg::NUM_CLS; c++) begin
                r_cnt[c] <= '0;
            end
        end else begin
            r_vld <= i_beat.valid;
            for (int c = 0; c < cdvh_pkg::NUM_CLS; c++) begin
                r_cnt[c] <= n_cnt[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pay <= n_pay;
    end

    always_comb begin
        o_beat       = r_pay;
        o_beat.valid = r_vld;
    end

endmodule

`default_nettype wire

/* design/cumulative_dose_volume_histogram_unit.sv */
// cumulative dose-volume histogram over a stream of voxels
// command channel: a beat is taken on a clock edge with i_start high and o_busy
// low; o_busy stays low, so a command can be issued every cycle
// i_cmd selects add voxel, query level or clear all counts; code 3 is dropped
// the counts live in a row of MAX_LEVEL+1 cells, one per level; each beat walks
// the row one cell per clock, so an add updates every level in order and a
// query picks up its counts at the cell of its level
// a query gives one result beat after it has walked all MAX_LEVEL+1 cells,
// shown for exactly one cycle with o_valid high; add and clear give none
// queries above MAX_LEVEL return the level with all counts zero
// config channel: i_cfg_valid / o_cfg_ready write dose_step; o_cfg_ready is high
// only when no command is travelling through the row
// reset (synchronous, active low) zeroes all counts at once and sets
// dose_step to 100; there is no clearing pass
// results cannot be held off by the receiver
`default_nettype none

module cumulative_dose_volume_histogram_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    output logic                                o_busy,
    input  wire logic [1:0]                     i_cmd,
    input  wire logic [cdvh_pkg::DOSE_W-1:0]    i_dose,
    input  wire logic                           i_in_prostate,
    input  wire logic                           i_in_urethra,
    input  wire logic                           i_in_rectum,
    input  wire logic [cdvh_pkg::LEVEL_W-1:0]   i_level,
    output logic                                o_valid,
    output logic [cdvh_pkg::LEVEL_W-1:0]        o_level_out,
    output logic [cdvh_pkg::OUT_CNT_W-1:0]      o_prostate_count,
    output logic [cdvh_pkg::OUT_CNT_W-1:0]      o_urethra_count,
    output logic [cdvh_pkg::OUT_CNT_W-1:0]      o_rectum_count,
    output logic [cdvh_pkg::OUT_CNT_W-1:0]      o_normal_count,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [cdvh_pkg::STEP_W-1:0]    i_cfg_data
);

    logic [cdvh_pkg::STEP_W-1:0]  r_dose_step;
    logic [cdvh_pkg::INFL_W-1:0]  r_inflight;
    logic [cdvh_pkg::INFL_W-1:0]  n_inflight;
    logic                         w_accept;
    logic                         w_exit;
    cdvh_pkg::t_beat              w_first;
    cdvh_pkg::t_beat              w_beat [cdvh_pkg::NUM_CELLS];
    cdvh_pkg::t_beat              w_last;

    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;

    always_comb begin
        w_first              = '0;
        w_first.valid        = w_accept;
        w_first.cmd          = cdvh_pkg::t_cmd'(i_cmd);
        w_first.below        = 1'b0;
        w_first.rem          = i_dose;
        w_first.unit         = {r_dose_step, {cdvh_pkg::FRAC_W{1'b0}}};
        w_first.level        = i_level;
        if (i_in_prostate) begin
            w_first.cls = cdvh_pkg::CLS_PROSTATE;
        end else if (i_in_urethra) begin
            w_first.cls = cdvh_pkg::CLS_URETHRA;
        end else if (i_in_rectum) begin
            w_first.cls = cdvh_pkg::CLS_RECTUM;
        end else begin
            w_first.cls = cdvh_pkg::CLS_NORMAL;
        end
    end

    for (genvar k = 0; k < cdvh_pkg::NUM_CELLS; k++) begin : g_cell
        if (k == 0) begin : g_head
            cdvh_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_index (cdvh_pkg::IDX_W'(k)),
                .i_beat  (w_first),
                .o_beat  (w_beat[k])
            );
        end else begin : g_body
            cdvh_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_index (cdvh_pkg::IDX_W'(k)),
                .i_beat  (w_beat[k-1]),
                .o_beat  (w_beat[k])
            );
        end
    end

    assign w_last = w_beat[cdvh_pkg::NUM_CELLS-1];
    assign w_exit = w_last.valid;

    assign o_valid          = w_last.valid && (w_last.cmd == cdvh_pkg::CMD_QUERY);
    assign o_level_out      = w_last.level;
    assign o_prostate_count = cdvh_pkg::OUT_CNT_W'(w_last.cnt_prostate);
    assign o_urethra_count  = cdvh_pkg::OUT_CNT_W'(w_last.cnt_urethra);
    assign o_rectum_count   = cdvh_pkg::OUT_CNT_W'(w_last.cnt_rectum);
    assign o_normal_count   = cdvh_pkg::OUT_CNT_W'(w_last.cnt_normal);

    // beats in the row
    always_comb begin
        n_inflight = r_inflight;
        if (w_accept && !w_exit) begin
            n_inflight = r_inflight + cdvh_pkg::INFL_W'(1);
        end else if (!w_accept && w_exit) begin
            n_inflight = r_inflight - cdvh_pkg::INFL_W'(1);
        end
    end

    assign o_cfg_ready = (r_inflight == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight  <= '0;
            r_dose_step <= cdvh_pkg::DOSE_STEP_RST;
        end else begin
            r_inflight <= n_inflight;
            if (i_cfg_valid && o_cfg_ready) begin
                r_dose_step <= i_cfg_data;
            end
        end
    end

    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_inflight != '0))
        else $error("result with no command in flight");

    a_ready_means_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !w_last.valid)
        else $error("config ready while a beat leaves the row");

    a_query_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_cmd == cdvh_pkg::CMD_QUERY)) |-> ##(cdvh_pkg::NUM_CELLS) o_valid)
        else $error("query result missing after row latency");

    a_high_level_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_level_out > cdvh_pkg::LEVEL_W'(cdvh_pkg::MAX_LEVEL)))
        |-> (o_prostate_count == '0 && o_urethra_count == '0
             && o_rectum_count == '0 && o_normal_count == '0))
        else $error("nonzero counts for a level beyond the histogram");

endmodule

`default_nettype wire

/* dv/tb_cumulative_dose_volume_histogram_unit.sv */
`default_nettype none

module tb_cumulative_dose_volume_histogram_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import cdvh_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int ROW_LAT = MAX_LEVEL + 12;
    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int NUM_PHASES = 5;
    localparam int UNIT_L1 = 100 << FRAC_W;

    typedef struct {
        logic [LEVEL_W-1:0]   lvl;
        logic [OUT_CNT_W-1:0] cnt [NUM_CLS];
    } dvh_row_t;

    class dvh_counts;
        logic [STEP_W-1:0]    step;
        logic [OUT_CNT_W-1:0] tally [NUM_CLS][0:MAX_LEVEL];
        dvh_row_t             rows [$];
        int                   mismatches;

        function new();
            step = DOSE_STEP_RST;
            mismatches = 0;
            clear_all();
        endfunction

        function void clear_all();
            for (int c = 0; c < NUM_CLS; c++)
                for (int l = 0; l <= MAX_LEVEL; l++)
                    tally[c][l] = '0;
        endfunction

        function void set_step(logic [STEP_W-1:0] v);
            step = v;
        endfunction

        function int pending();
            return rows.size();
        endfunction

        function void note_item(logic [1:0] cmd, logic [DOSE_W-1:0] dose, logic pr, logic ur,
                                logic re, logic [LEVEL_W-1:0] lvl);
            t_cls        cls_id;
            dvh_row_t    row;
            logic [63:0] unit;
            case (cmd)
                CMD_ADD: begin
                    if (pr)
                        cls_id = CLS_PROSTATE;
                    else if (ur)
                        cls_id = CLS_URETHRA;
                    else if (re)
                        cls_id = CLS_RECTUM;
                    else
                        cls_id = CLS_NORMAL;
                    unit = 64'(step) << FRAC_W;
                    for (int l = 0; l <= MAX_LEVEL; l++)
                        if (64'(dose) >= 64'(l) * unit && tally[cls_id][l] < MAX_VOXELS)
                            tally[cls_id][l] = tally[cls_id][l] + 1'b1;
                end
                CMD_QUERY: begin
                    row.lvl = lvl;
                    for (int c = 0; c < NUM_CLS; c++)
                        row.cnt[c] = (lvl <= MAX_LEVEL) ? tally[c][lvl] : '0;
                    rows.insert(rows.size(), row);
                end
                CMD_CLEAR: clear_all();
                default: ;
            endcase
        endfunction

        task report(string what, longint unsigned got, longint unsigned want);
            mismatches++;
            $display("[%0t] %s: got %0d want %0d", $time, what, got, want);
        endtask

        task check_result(logic [LEVEL_W-1:0] lvl, logic [OUT_CNT_W-1:0] p,
                          logic [OUT_CNT_W-1:0] u, logic [OUT_CNT_W-1:0] r,
                          logic [OUT_CNT_W-1:0] n);
            dvh_row_t             want;
            logic [OUT_CNT_W-1:0] got [NUM_CLS];
            t_cls                 cls_id;
            got = '{p, u, r, n};
            if (rows.size() == 0) begin
                report("result beat with no query pending, level", lvl, 0);
                return;
            end
            want = rows.pop_front();
            if (lvl !== want.lvl)
                report("level_out", lvl, want.lvl);
            for (int c = 0; c < NUM_CLS; c++) begin
                cls_id = t_cls'(c);
                if (got[c] !== want.cnt[c])
                    report($sformatf("%s count at level %0d", cls_id.name(), want.lvl),
                           got[c], want.cnt[c]);
            end
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_start;
    logic                 o_busy;
    logic [1:0]           i_cmd;
    logic [DOSE_W-1:0]    i_dose;
    logic                 i_in_prostate;
    logic                 i_in_urethra;
    logic                 i_in_rectum;
    logic [LEVEL_W-1:0]   i_level;
    logic                 o_valid;
    logic [LEVEL_W-1:0]   o_level_out;
    logic [OUT_CNT_W-1:0] o_prostate_count;
    logic [OUT_CNT_W-1:0] o_urethra_count;
    logic [OUT_CNT_W-1:0] o_rectum_count;
    logic [OUT_CNT_W-1:0] o_normal_count;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [STEP_W-1:0]    i_cfg_data;

    dvh_counts            sb;
    logic [STEP_W-1:0]    cur_step = DOSE_STEP_RST;
    bit                   idle_on = 1'b1;
    int                   cycle_count = 0;
    logic [STEP_W-1:0]    phase_steps [NUM_PHASES];

    cumulative_dose_volume_histogram_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .o_busy           (o_busy),
        .i_cmd            (i_cmd),
        .i_dose           (i_dose),
        .i_in_prostate    (i_in_prostate),
        .i_in_urethra     (i_in_urethra),
        .i_in_rectum      (i_in_rectum),
        .i_level          (i_level),
        .o_valid          (o_valid),
        .o_level_out      (o_level_out),
        .o_prostate_count (o_prostate_count),
        .o_urethra_count  (o_urethra_count),
        .o_rectum_count   (o_rectum_count),
        .o_normal_count   (o_normal_count),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid)
                sb.check_result(o_level_out, o_prostate_count, o_urethra_count,
                                o_rectum_count, o_normal_count);
            if (i_start && !o_busy)
                sb.note_item(i_cmd, i_dose, i_in_prostate, i_in_urethra, i_in_rectum, i_level);
            if (i_cfg_valid && o_cfg_ready)
                sb.set_step(i_cfg_data);
        end
    end

    // one command beat, with an optional idle burst ahead of it
    task automatic drive_item(logic [1:0] cmd, logic [DOSE_W-1:0] dose, bit pr, bit ur, bit re,
                              logic [LEVEL_W-1:0] lvl);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_start       <= 1'b1;
        i_cmd         <= cmd;
        i_dose        <= dose;
        i_in_prostate <= pr;
        i_in_urethra  <= ur;
        i_in_rectum   <= re;
        i_level       <= lvl;
        @(posedge i_clk);
        while (o_busy)
            @(posedge i_clk);
    endtask

    task automatic query(logic [LEVEL_W-1:0] lvl);
        drive_item(CMD_QUERY, $urandom(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), lvl);
    endtask

    task automatic add_voxel(logic [DOSE_W-1:0] dose, bit pr, bit ur, bit re);
        drive_item(CMD_ADD, dose, pr, ur, re, LEVEL_W'($urandom_range(0, 511)));
    endtask

    task automatic write_step(logic [STEP_W-1:0] v);
        i_start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (ROW_LAT) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_step = v;
    endtask

    task automatic random_item();
        logic [1:0]        cmd;
        logic [DOSE_W-1:0] dose;
        logic [LEVEL_W-1:0] lvl;
        longint            near;
        int                pick;
        int                off;
        pick = $urandom_range(0, 99);
        if (pick < 78)
            cmd = CMD_ADD;
        else if (pick < 94)
            cmd = CMD_QUERY;
        else if (pick < 97)
            cmd = CMD_CLEAR;
        else
            cmd = CMD_UNUSED;
        case ($urandom_range(0, 3))
            0: dose = $urandom();
            1: dose = $urandom_range(0, 32'h0001_0000);
            default: begin
                // land on or next to a level threshold
                off  = $urandom_range(0, 2);
                near = longint'($urandom_range(0, MAX_LEVEL)) * (longint'(cur_step) << FRAC_W)
                       + longint'(off) - 1;
                dose = (near < 0 || near >= (longint'(1) << 32)) ? $urandom() : near[31:0];
            end
        endcase
        lvl = ($urandom_range(0, 6) == 0) ? LEVEL_W'($urandom_range(MAX_LEVEL + 1, 511))
                                          : LEVEL_W'($urandom_range(0, MAX_LEVEL));
        drive_item(cmd, dose, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), lvl);
    endtask

    initial begin
        sb = new();
        i_rst_n       <= 1'b0;
        i_start       <= 1'b0;
        i_cmd         <= CMD_ADD;
        i_dose        <= '0;
        i_in_prostate <= 1'b0;
        i_in_urethra  <= 1'b0;
        i_in_rectum   <= 1'b0;
        i_level       <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        phase_steps = '{16'd0, 16'hFFFF, 16'd1, 16'd0, DOSE_STEP_RST};
        phase_steps[3] = STEP_W'($urandom_range(2, 16'hFFFE));
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset counts, thresholds, class priority, odd codes
        query(0);
        add_voxel(32'd0, 1'b0, 1'b0, 1'b0);
        add_voxel(UNIT_L1, 1'b1, 1'b0, 1'b0);
        add_voxel(UNIT_L1 - 1, 1'b0, 1'b1, 1'b0);
        add_voxel(2 * UNIT_L1, 1'b0, 1'b0, 1'b1);
        add_voxel(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
        add_voxel(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1);
        add_voxel(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1);
        add_voxel(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
        add_voxel(MAX_LEVEL * UNIT_L1, 1'b0, 1'b0, 1'b0);
        add_voxel(MAX_LEVEL * UNIT_L1 - 1, 1'b0, 1'b0, 1'b1);
        query(0);
        query(1);
        query(2);
        query(LEVEL_W'(MAX_LEVEL - 1));
        query(LEVEL_W'(MAX_LEVEL));
        query(LEVEL_W'(MAX_LEVEL + 1));
        query(9'h1FF);
        drive_item(CMD_UNUSED, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 9'd1);
        query(1);
        drive_item(CMD_CLEAR, 32'hA5A5_5A5A, 1'b1, 1'b0, 1'b1, 9'h155);
        query(0);
        query(LEVEL_W'(MAX_LEVEL));

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_step(phase_steps[ph]);
            idle_on = (ph != NUM_PHASES - 1);
            repeat (ITEMS_PER_PHASE) random_item();
        end

        i_start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (ROW_LAT) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
design/cdvh_pkg.sv
design/cdvh_cell.sv
design/cumulative_dose_volume_histogram_unit.sv
dv/tb_cumulative_dose_volume_histogram_unit.sv
